/* rtl/core/asn1_ber_header_encoder_unit_assert.svh */
// Assertion macros shared by the BER header encoder RTL.
`ifndef ASN1_BER_HEADER_ENCODER_UNIT_ASSERT_SVH
`define ASN1_BER_HEADER_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ABER_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ABER_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ABER_ASSERT_IMP(name, ante, cons, msg)
`define ABER_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

/* rtl/core/aber_pkg.sv */
// Shared types and constants of the BER header encoder.
package aber_pkg;

  localparam int unsigned MaxLenBytesDef = 8;

  localparam int unsigned TagW     = 64;
  localparam int unsigned LenFieldW = 63;
  localparam int unsigned TagGroups = 10;

  localparam logic [63:0] ShortTagLimit = 64'd31;
  localparam logic [62:0] ShortLenLimit = 63'd128;
  localparam logic [7:0]  LongLenFlag   = 8'h80;
  localparam logic [4:0]  LongTagMark   = 5'h1F;

  typedef enum logic {
    OpHeader = 1'b0,
    OpFooter = 1'b1
  } aber_op_e;

  typedef struct packed {
    aber_op_e               op;
    logic [1:0]             tag_class;
    logic                   constructed;
    logic [TagW-1:0]        tag_number;
    logic                   indefinite;
    logic [LenFieldW-1:0]   content_length;
  } aber_item_t;

endpackage

/* rtl/core/aber_build.sv */
// Combinational encoder that turns one node description into a left-aligned byte string.
module aber_build import aber_pkg::*; #(
  parameter int unsigned MaxLenBytes = MaxLenBytesDef,
  parameter int unsigned StreamW     = 8 * (12 + MaxLenBytes),
  parameter int unsigned CntW        = $clog2(12 + MaxLenBytes + 1)
) (
  input  aber_item_t         item_i,
  output logic [StreamW-1:0] stream_o,
  output logic [CntW-1:0]    count_o
);

  localparam int unsigned LenW = 8 * MaxLenBytes;

  logic [69:0]      tag70;
  logic [3:0]       ngroups;
  logic             tag_long;
  logic [3:0]       ntag;
  logic [79:0]      tag_full;
  logic [79:0]      tag_al;
  logic [7:0]       ido;
  logic [63:0]      len64;
  logic [3:0]       nb_min;
  logic [3:0]       nb;
  logic             len_sat;
  logic [LenW-1:0]  len_bytes;
  logic [LenW-1:0]  len_bytes_al;
  logic [7:0]       len_hdr;
  logic [3:0]       len_cnt;
  logic [LenW+7:0]  len_al;

  assign tag70    = {6'b0, item_i.tag_number};
  assign tag_long = item_i.tag_number >= ShortTagLimit;
  assign ntag     = tag_long ? ngroups : 4'd0;
  assign len64    = {1'b0, item_i.content_length};

  // Count of base-128 groups needed for the tag and of bytes for the length.
  always_comb begin
    ngroups = 4'd1;
    for (int g = 1; g < TagGroups; g++) begin
      if ((tag70 >> (7 * g)) != 70'd0) ngroups = 4'(g + 1);
    end
    nb_min = 4'd1;
    for (int b = 1; b < 8; b++) begin
      if ((len64 >> (8 * b)) != 64'd0) nb_min = 4'(b + 1);
    end
  end

  // Tag octets with the most significant group in the top byte; all carry
  // the continuation bit except group zero.
  always_comb begin
    for (int g = 0; g < TagGroups; g++) begin
      tag_full[8*g +: 8] = {(g != 0), tag70[7*g +: 7]};
    end
  end

  assign tag_al = tag_full << {4'(4'd10 - ntag), 3'b000};
  assign ido    = {item_i.tag_class, item_i.constructed,
                   tag_long ? LongTagMark : item_i.tag_number[4:0]};

  assign len_sat   = nb_min > 4'(MaxLenBytes);
  assign nb        = len_sat ? 4'(MaxLenBytes) : nb_min;
  assign len_bytes = len_sat ? {LenW{1'b1}} : len64[LenW-1:0];

  always_comb begin
    len_bytes_al = '0;
    if (item_i.indefinite) begin
      len_hdr = LongLenFlag;
      len_cnt = 4'd1;
    end else if (item_i.content_length < ShortLenLimit) begin
      len_hdr = item_i.content_length[7:0];
      len_cnt = 4'd1;
    end else begin
      len_hdr      = LongLenFlag | {4'b0, nb};
      len_cnt      = nb + 4'd1;
      len_bytes_al = len_bytes << {4'(4'(MaxLenBytes) - nb), 3'b000};
    end
  end

  assign len_al = {len_hdr, len_bytes_al};

  always_comb begin
    if (item_i.op == OpFooter) begin
      // End-of-contents is two zero bytes, only for the indefinite form.
      stream_o = '0;
      count_o  = item_i.indefinite ? CntW'(2) : '0;
    end else begin
      stream_o = {ido, tag_al, {(LenW + 8){1'b0}}} |
                 ({8'b0, len_al, 80'b0} >> {ntag, 3'b000});
      count_o  = CntW'(1) + CntW'(ntag) + CntW'(len_cnt);
    end
  end

endmodule

/* rtl/core/aber_serial.sv */
// Result register that shifts an encoded byte string out one word at a time.
module aber_serial import aber_pkg::*; #(
  parameter int unsigned StreamW = 160,
  parameter int unsigned CntW    = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [StreamW-1:0] stream_i,
  input  logic [CntW-1:0]    count_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic [7:0]         byte_o,
  output logic               last_o,
  input  logic               take_ready_i
);

  logic [StreamW-1:0] data_q;
  logic [CntW-1:0]    rem_q;
  logic               valid_q;
  logic               take;

  assign take    = valid_q && take_ready_i;
  assign last_o  = rem_q == CntW'(1);
  assign ready_o = !valid_q || (take && last_o);
  assign valid_o = valid_q;
  assign byte_o  = data_q[StreamW-1 -: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      rem_q   <= count_i;
    end else if (take) begin
      rem_q <= rem_q - CntW'(1);
      if (last_o) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= stream_i;
    end else if (take) begin
      data_q <= data_q << 8;
    end
  end

endmodule

/* rtl/core/asn1_ber_header_encoder_unit.sv */
// ASN.1 BER header encoder top level: each input word describes one node and
// yields its identifier and length octets, or its end-of-contents footer, as a
// stream of byte-wide output words with tlast on the final byte. An input word
// lands in an input register; the whole byte string is formed combinationally
// from it and loaded into a result register that shifts out one byte per
// cycle while the output is ready. An item has from 2 up to 12 + MaxLenBytes
// bytes (20 at the default); a footer without the indefinite flag produces
// no output and leaves the input register without waiting for the result
// register. The output shift register is the limit: while it drains, the
// next item waits in the input register, so a new word is taken in the same
// cycle the previous item's last byte leaves, and in every cycle for items
// that produce nothing. Length values needing more than MaxLenBytes bytes are
// sent as MaxLenBytes bytes of 0xFF.
`include "asn1_ber_header_encoder_unit_assert.svh"

module asn1_ber_header_encoder_unit import aber_pkg::*; #(
  parameter int unsigned MaxLenBytes = MaxLenBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata, from bit 0: tag_class[1:0], constructed[2], tag_number[66:3],
  // indefinite[67], content_length[130:68], zero fill [135:131].
  input  logic [135:0] s_axis_tdata_i,
  // tuser: op (0 header, 1 end-of-contents footer).
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: out_byte[7:0].
  output logic [7:0]   m_axis_tdata_o,
  // tlast: final_byte, set on the last byte of an item.
  output logic         m_axis_tlast_o
);

  localparam int unsigned StreamW = 8 * (12 + MaxLenBytes);
  localparam int unsigned CntW    = $clog2(12 + MaxLenBytes + 1);

  aber_item_t         s1_item_q;
  logic               s1_valid_q;
  logic               s1_adv;
  logic               in_take;
  logic               ser_ready;
  logic               ser_load;
  logic [StreamW-1:0] build_stream;
  logic [CntW-1:0]    build_cnt;

  // The input register advances when the result register is free, or at
  // once when the item produces no bytes at all.
  assign s1_adv          = s1_valid_q && (ser_ready || build_cnt == '0);
  assign ser_load        = s1_valid_q && ser_ready && build_cnt != '0;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.op             <= aber_op_e'(s_axis_tuser_i);
      s1_item_q.tag_class      <= s_axis_tdata_i[1:0];
      s1_item_q.constructed    <= s_axis_tdata_i[2];
      s1_item_q.tag_number     <= s_axis_tdata_i[66:3];
      s1_item_q.indefinite     <= s_axis_tdata_i[67];
      s1_item_q.content_length <= s_axis_tdata_i[130:68];
    end
  end

  aber_build #(
    .MaxLenBytes (MaxLenBytes),
    .StreamW     (StreamW),
    .CntW        (CntW)
  ) u_build (
    .item_i   (s1_item_q),
    .stream_o (build_stream),
    .count_o  (build_cnt)
  );

  aber_serial #(
    .StreamW (StreamW),
    .CntW    (CntW)
  ) u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ser_load),
    .stream_i     (build_stream),
    .count_i      (build_cnt),
    .ready_o      (ser_ready),
    .valid_o      (m_axis_tvalid_o),
    .byte_o       (m_axis_tdata_o),
    .last_o       (m_axis_tlast_o),
    .take_ready_i (m_axis_tready_i)
  );

  // A word taken before the last byte of an item means more bytes follow.
  `ABER_ASSERT_NXT(a_item_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o, "item output ended without tlast")
  // A footer that reaches the output is always the two end-of-contents bytes.
  `ABER_ASSERT_IMP(a_footer_two_bytes, ser_load && s1_item_q.op == OpFooter, build_cnt == CntW'(2) && s1_item_q.indefinite, "footer loaded with wrong byte count")
  // The result register is only loaded when its previous item is finished.
  `ABER_ASSERT_IMP(a_load_when_free, ser_load, !m_axis_tvalid_o || (m_axis_tready_i && m_axis_tlast_o), "result register overwritten")
  // An accepted word is held in the input register on the next cycle.
  `ABER_ASSERT_NXT(a_input_held, in_take, s1_valid_q, "accepted word lost")

endmodule

/* verif/tb.sv */
// Self-checking testbench for the BER identifier and length octet encoder.
module tb import aber_pkg::*; ();

  localparam int unsigned RandItems  = 400;
  localparam int unsigned CalmItems  = 60;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainWait  = 40;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } octet_t;

  // Directed row: n_typed < 0 means the expected bytes come from the encoder
  // model; otherwise the first n_typed bytes of typed (right aligned, first
  // byte leftmost) are the expected output.
  typedef struct {
    aber_item_t  item;
    int          n_typed;
    logic [95:0] typed;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_valid;
  logic [135:0] s_data;
  logic         s_user;
  logic         m_ready;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [7:0]   m_axis_tdata_o;
  logic         m_axis_tlast_o;

  octet_t      exp_octets[$];
  stim_row_t   dir_rows[$];
  int unsigned err_cnt    = 0;
  int unsigned bytes_seen = 0;
  int unsigned stuck_cnt  = 0;
  bit          calm       = 1'b0;

  always #2 clk_i = ~clk_i;

  asn1_ber_header_encoder_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // Expected byte string of one node, appended to exp_octets.
  function automatic void encode_tlv_header(input aber_item_t it);
    logic [7:0]  octs[$];
    logic [7:0]  ident;
    logic [63:0] tag;
    logic [63:0] lenv;
    int          groups;
    int          nbytes;
    tag  = it.tag_number;
    lenv = {1'b0, it.content_length};
    if (it.op == OpFooter) begin
      if (it.indefinite) begin
        octs.push_back(8'h00);
        octs.push_back(8'h00);
      end
    end else begin
      ident = {it.tag_class, it.constructed, 5'd0};
      ident[4:0] = (tag < ShortTagLimit) ? tag[4:0] : LongTagMark;
      octs.push_back(ident);
      if (tag >= ShortTagLimit) begin
        // Base-128 groups, most significant first, continuation bit on all
        // but the last.
        groups = 1;
        while (groups < TagGroups && (tag >> (7 * groups)) != 64'd0) groups++;
        for (int g = groups - 1; g >= 0; g--) begin
          octs.push_back({g != 0, 7'(tag >> (7 * g))});
        end
      end
      if (it.indefinite) begin
        octs.push_back(LongLenFlag);
      end else if (it.content_length < ShortLenLimit) begin
        octs.push_back(lenv[7:0]);
      end else begin
        nbytes = 1;
        while (nbytes < 8 && (lenv >> (8 * nbytes)) != 64'd0) nbytes++;
        if (nbytes > MaxLenBytesDef) begin
          nbytes = MaxLenBytesDef;
          lenv   = '1;
        end
        octs.push_back(LongLenFlag | 8'(nbytes));
        for (int b = nbytes - 1; b >= 0; b--) begin
          octs.push_back(8'(lenv >> (8 * b)));
        end
      end
    end
    foreach (octs[i]) begin
      exp_octets.push_back('{value: octs[i], last: (i == octs.size() - 1)});
    end
  endfunction

  function automatic logic [63:0] rand_bits(input int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (w >= 64) ? r : (r & ((64'd1 << w) - 64'd1));
  endfunction

  function automatic aber_item_t random_item();
    aber_item_t it;
    it.op             = ($urandom_range(0, 99) < 15) ? OpFooter : OpHeader;
    it.tag_class      = 2'($urandom_range(0, 3));
    it.constructed    = 1'($urandom_range(0, 1));
    it.indefinite     = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0: it.tag_number = 64'($urandom_range(0, 30));
      1: it.tag_number = ($urandom_range(0, 1) ? 64'd126 : 64'd29) + $urandom_range(0, 4);
      2: it.tag_number = rand_bits($urandom_range(1, 64));
      default: it.tag_number = rand_bits(64);
    endcase
    case ($urandom_range(0, 3))
      0: it.content_length = 63'($urandom_range(0, 127));
      1: it.content_length = 63'($urandom_range(126, 130));
      2: it.content_length = 63'(rand_bits($urandom_range(1, 63)));
      default: it.content_length = 63'(rand_bits(63));
    endcase
    if (it.op == OpFooter && $urandom_range(0, 1)) it.indefinite = 1'b1;
    return it;
  endfunction

  task automatic add_row(input aber_op_e op, input logic [1:0] cls, input logic cons,
                         input logic [63:0] tag, input logic indef, input logic [62:0] len,
                         input int n_typed, input logic [95:0] typed);
    stim_row_t r;
    r.item    = '{op: op, tag_class: cls, constructed: cons, tag_number: tag,
                  indefinite: indef, content_length: len};
    r.n_typed = n_typed;
    r.typed   = typed;
    dir_rows.push_back(r);
  endtask

  // Present one word and hold it until the block takes it.
  task automatic offer_word(input aber_item_t it);
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {5'd0, it.content_length, it.indefinite, it.tag_number,
                it.constructed, it.tag_class};
    s_user  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic sender_pause();
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Sender: reset, directed table, random words, then drain and verdict.
  initial begin
    aber_item_t it;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = 1'b0;
    rst_ni  = 1'b0;

    add_row(OpHeader, 2'd0, 1'b0, 64'd0, 1'b0, 63'd0, 2, 96'({8'h00, 8'h00}));
    add_row(OpFooter, 2'd0, 1'b0, 64'd0, 1'b1, 63'd0, 2, 96'({8'h00, 8'h00}));
    add_row(OpFooter, 2'd0, 1'b0, 64'd0, 1'b0, 63'd0, 0, '0);
    add_row(OpHeader, 2'd3, 1'b1, 64'd30, 1'b0, 63'd127, 2, 96'({8'hFE, 8'h7F}));
    add_row(OpHeader, 2'd1, 1'b0, 64'd31, 1'b0, 63'd0, 3, 96'({8'h5F, 8'h1F, 8'h00}));
    add_row(OpHeader, 2'd2, 1'b0, 64'd5, 1'b0, 63'd128, 3, 96'({8'h85, 8'h81, 8'h80}));
    // Indefinite header ignores the length; footers ignore everything but the flag.
    add_row(OpHeader, 2'd2, 1'b1, 64'd0, 1'b1, '1, 2, 96'({8'hA0, 8'h80}));
    add_row(OpFooter, 2'd3, 1'b1, '1, 1'b1, '1, 2, 96'({8'h00, 8'h00}));
    add_row(OpFooter, 2'd3, 1'b1, '1, 1'b0, '1, 0, '0);
    add_row(OpHeader, 2'd0, 1'b1, 64'd127, 1'b0, 63'd255, -1, '0);
    add_row(OpHeader, 2'd1, 1'b1, 64'd128, 1'b0, 63'd256, -1, '0);
    add_row(OpHeader, 2'd2, 1'b0, 64'd16383, 1'b0, 63'd65535, -1, '0);
    add_row(OpHeader, 2'd3, 1'b0, 64'd16384, 1'b0, 63'd65536, -1, '0);
    add_row(OpHeader, 2'd1, 1'b0, 64'h8000_0000_0000_0000, 1'b0,
            63'h4000_0000_0000_0000, -1, '0);
    add_row(OpHeader, 2'd0, 1'b0, 64'h00FF_FFFF_FFFF_FFFF, 1'b0,
            63'h00FF_FFFF_FFFF_FFFF, -1, '0);
    // Longest possible header: ten tag octets and eight length bytes.
    add_row(OpHeader, 2'd3, 1'b1, '1, 1'b0, '1, -1, '0);
    add_row(OpHeader, 2'd2, 1'b1, '1, 1'b1, 63'd0, -1, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k]) begin
      offer_word(dir_rows[k].item);
      if (dir_rows[k].n_typed < 0) begin
        encode_tlv_header(dir_rows[k].item);
      end else begin
        for (int i = 0; i < dir_rows[k].n_typed; i++) begin
          exp_octets.push_back('{value: dir_rows[k].typed[8 * (dir_rows[k].n_typed - 1 - i) +: 8],
                                 last: (i == dir_rows[k].n_typed - 1)});
        end
      end
      sender_pause();
    end

    for (int n = 0; n < RandItems; n++) begin
      if (n >= RandItems - CalmItems) calm = 1'b1;
      it = random_item();
      offer_word(it);
      encode_tlv_header(it);
      sender_pause();
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (exp_octets.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[asn1_ber_header_encoder_unit] OK");
    end else begin
      $display("[asn1_ber_header_encoder_unit] ERROR");
    end
    $finish;
  end

  // Receiver: short random stalls, one long hold once output is flowing so the
  // block backs up into its input, and a steady tail with no stalls.
  initial begin
    int  stall_left;
    bit  held_long;
    stall_left = 0;
    held_long  = 1'b0;
    m_ready    = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else if (!calm && !held_long && bytes_seen >= HoldAfter) begin
        held_long  = 1'b1;
        stall_left = LongHold - 1;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Output check: every accepted byte against the oldest expectation.
  always @(posedge clk_i) begin
    octet_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      bytes_seen++;
      if (exp_octets.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        want = exp_octets.pop_front();
        if (m_axis_tdata_o !== want.value) begin
          flag_mismatch($sformatf("byte %02h, expected %02h", m_axis_tdata_o, want.value));
        end
        if (m_axis_tlast_o !== want.last) begin
          flag_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast_o, want.last));
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        stuck_cnt <= 0;
      end else if (stuck_cnt >= StuckLimit) begin
        $display("[asn1_ber_header_encoder_unit] ERROR");
        $finish;
      end else begin
        stuck_cnt <= stuck_cnt + 1;
      end
    end
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/aber_pkg.sv
rtl/core/aber_build.sv
rtl/core/aber_serial.sv
rtl/core/asn1_ber_header_encoder_unit.sv
verif/tb.sv
